FILE: hw/rtl/pdct_pkg.sv
// package for the prescaled down-counter timer
// opcodes, register indexes, word field widths and the divider table; no dependencies

package pdct_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int DATA_WIDTH          = 16;
    localparam int OPCODE_WIDTH        = 2;
    localparam int CFG_INDEX_WIDTH     = 8;
    localparam int CFG_DATA_WIDTH      = 8;
    localparam int PRESCALE_WIDTH      = 8;
    localparam int DIVCODE_WIDTH       = 3;
    localparam int DIVCOUNT_WIDTH      = 5;

    typedef logic [OPCODE_WIDTH-1:0]    opcode_t;
    typedef logic [DATA_WIDTH-1:0]      data_t;
    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
    typedef logic [CFG_DATA_WIDTH-1:0]  cfg_data_t;
    typedef logic [DIVCODE_WIDTH-1:0]   divcode_t;
    typedef logic [DIVCOUNT_WIDTH-1:0]  divcount_t;

    localparam opcode_t OP_TICK        = 2'd0;
    localparam opcode_t OP_WRITE_BUF   = 2'd1;
    localparam opcode_t OP_WRITE_CTRL  = 2'd2;
    localparam opcode_t OP_READ_COUNT  = 2'd3;

    localparam cfg_index_t REG_PRESCALE = 8'd0;
    localparam cfg_index_t REG_DIVIDER  = 8'd1;

    localparam int CTRL_START_BIT  = 0;
    localparam int CTRL_UPDATE_BIT = 1;
    localparam int CTRL_RELOAD_BIT = 3;

    // last divider count before wrap; codes above four act as four
    function automatic divcount_t divide_top(input divcode_t code);
        divcount_t top;
        case (code)
            3'd0:    top = 5'd1;
            3'd1:    top = 5'd3;
            3'd2:    top = 5'd7;
            3'd3:    top = 5'd15;
            default: top = 5'd31;
        endcase
        return top;
    endfunction

endpackage

FILE: hw/rtl/pdct_if.sv
// valid/ready channel interfaces for the prescaled down-counter timer
// command, response and configuration words; depends on pdct_pkg

interface pdct_cmd_if;
    logic                     valid;
    logic                     ready;
    pdct_pkg::opcode_t        opcode;
    pdct_pkg::data_t          write_data;

    modport source (output valid, output opcode, output write_data, input ready);
    modport sink   (input valid, input opcode, input write_data, output ready);
endinterface

interface pdct_rsp_if;
    logic                     valid;
    logic                     ready;
    pdct_pkg::data_t          read_data;
    logic                     count_is_zero;
    logic                     interrupt_pulse;

    modport source (output valid, output read_data, output count_is_zero,
                    output interrupt_pulse, input ready);
    modport sink   (input valid, input read_data, input count_is_zero,
                    input interrupt_pulse, output ready);
endinterface

interface pdct_cfg_if;
    logic                     valid;
    logic                     ready;
    pdct_pkg::cfg_index_t     index;
    pdct_pkg::cfg_data_t      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/prescaled_down_counter_timer_unit.sv
// prescaled down-counter timer: one channel with 8-bit prescaler, divider and down counter
// depends on pdct_pkg and the channel interfaces in pdct_if
//
// usage
//   cmd: one word per operation (tick, write count buffer, write control, read count)
//   rsp: exactly one word per cmd word, in order: read_data, count_is_zero, interrupt_pulse
//   cfg: register writes, index 0 prescale value, index 1 divider code; always ready,
//        written only while no cmd word is outstanding; the user keeps to this, unchecked
// latency: the response word is valid the cycle after its cmd word is accepted
// throughput: one cmd word per cycle unless stalled; the whole update is one pass of logic
//   between the state registers and the response register
// stall: cmd ready is low only while a response waits and rsp ready is low,
//   so the response register doubles as the skid stage
// reset: counter, buffer, prescaler and divider cleared, channel stopped and
//   one shot, registers zero, no response pending

module prescaled_down_counter_timer_unit #(
    parameter int COUNT_WIDTH = pdct_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    pdct_cmd_if.sink   cmd,
    pdct_rsp_if.source rsp,
    pdct_cfg_if.sink   cfg
);
    import pdct_pkg::*;

    logic [PRESCALE_WIDTH-1:0] prescale_value_reg;
    divcode_t                  divider_code_reg;
    logic [PRESCALE_WIDTH-1:0] prescale_count_reg, prescale_count_next;
    divcount_t                 divide_count_reg, divide_count_next;
    logic [COUNT_WIDTH-1:0]    current_count_reg, current_count_next;
    logic [COUNT_WIDTH-1:0]    count_buffer_reg, count_buffer_next;
    logic                      running_reg, running_next;
    logic                      reload_reg, reload_next;

    logic                      rsp_valid_reg;
    data_t                     read_data_reg, read_data_next;
    logic                      zero_reg, zero_next;
    logic                      pulse_reg, pulse_next;

    logic                      cmd_fire;
    logic                      pre_wrap;
    logic                      div_wrap;
    logic                      count_event;
    logic [COUNT_WIDTH-1:0]    data_ext;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.read_data       = read_data_reg;
    assign rsp.count_is_zero   = zero_reg;
    assign rsp.interrupt_pulse = pulse_reg;

    assign data_ext    = COUNT_WIDTH'(cmd.write_data);
    assign pre_wrap    = prescale_count_reg >= prescale_value_reg;
    assign div_wrap    = divide_count_reg >= divide_top(divider_code_reg);
    assign count_event = pre_wrap && div_wrap && running_reg;

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        divide_count_next   = divide_count_reg;
        current_count_next  = current_count_reg;
        count_buffer_next   = count_buffer_reg;
        running_next        = running_reg;
        reload_next         = reload_reg;
        pulse_next          = 1'b0;
        read_data_next      = '0;

        case (cmd.opcode)
            OP_TICK:
            begin
                // prescaler and divider run whether or not the channel runs
                if (pre_wrap)
                begin
                    prescale_count_next = '0;
                    if (div_wrap)
                        divide_count_next = '0;
                    else
                        divide_count_next = divide_count_reg + 1'b1;
                end
                else
                begin
                    prescale_count_next = prescale_count_reg + 1'b1;
                end

                if (count_event)
                begin
                    if (current_count_reg == '0)
                    begin
                        if (reload_reg)
                        begin
                            current_count_next = count_buffer_reg;
                            pulse_next         = (count_buffer_reg == '0);
                        end
                        else
                        begin
                            running_next = 1'b0;
                        end
                    end
                    else
                    begin
                        current_count_next = current_count_reg - 1'b1;
                        if (current_count_reg == COUNT_WIDTH'(1))
                        begin
                            pulse_next = 1'b1;
                            if (!reload_reg)
                                running_next = 1'b0;
                        end
                    end
                end
            end
            OP_WRITE_BUF:
            begin
                count_buffer_next = data_ext;
            end
            OP_WRITE_CTRL:
            begin
                if (cmd.write_data[CTRL_UPDATE_BIT])
                    current_count_next = count_buffer_reg;
                running_next = cmd.write_data[CTRL_START_BIT];
                reload_next  = cmd.write_data[CTRL_RELOAD_BIT];
            end
            OP_READ_COUNT:
            begin
                read_data_next = DATA_WIDTH'(current_count_reg);
            end
            default:
            begin
                read_data_next = '0;
            end
        endcase

        zero_next = (current_count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_value_reg <= '0;
            divider_code_reg   <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == REG_PRESCALE)
                prescale_value_reg <= cfg.data;
            else if (cfg.index == REG_DIVIDER)
                divider_code_reg <= cfg.data[DIVCODE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            divide_count_reg   <= '0;
            current_count_reg  <= '0;
            count_buffer_reg   <= '0;
            running_reg        <= 1'b0;
            reload_reg         <= 1'b0;
        end
        else if (cmd_fire)
        begin
            prescale_count_reg <= prescale_count_next;
            divide_count_reg   <= divide_count_next;
            current_count_reg  <= current_count_next;
            count_buffer_reg   <= count_buffer_next;
            running_reg        <= running_next;
            reload_reg         <= reload_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd_fire)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    // response word, held while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            read_data_reg <= read_data_next;
            zero_reg      <= zero_next;
            pulse_reg     <= pulse_next;
        end
    end

endmodule

FILE: test/tb.sv
// testbench for prescaled_down_counter_timer_unit: drives timer operations and register
// writes, predicts every response word and checks it in order
// depends on pdct_pkg, the channel interfaces in pdct_if and the timer unit

module tb;
    import pdct_pkg::*;

    localparam cfg_index_t FIRST_UNUSED_INDEX = REG_DIVIDER + 1'b1;
    localparam cfg_index_t LAST_INDEX         = '1;

    typedef struct packed {
        data_t read_data;
        logic  count_is_zero;
        logic  interrupt_pulse;
    } timer_word_t;

    class timer_scoreboard;
        logic [PRESCALE_WIDTH-1:0] prescale_value = '0;
        divcode_t                  divider_code   = '0;
        logic [PRESCALE_WIDTH-1:0] prescale_count = '0;
        divcount_t                 divide_count   = '0;
        data_t                     current_count  = '0;
        data_t                     count_buffer   = '0;
        bit                        running        = 1'b0;
        bit                        reload_enable  = 1'b0;
        timer_word_t               expected_words[$];
        int                        mismatches     = 0;

        function void set_register(cfg_index_t idx, cfg_data_t val);
            if (idx == REG_PRESCALE)
                prescale_value = val;
            else if (idx == REG_DIVIDER)
                divider_code = val[DIVCODE_WIDTH-1:0];
        endfunction

        function void note_command(opcode_t op, data_t wd);
            timer_word_t w;
            int          last_div;
            bit          fire;
            w = '0;
            fire = 1'b0;
            case (op)
                OP_TICK:
                begin
                    // codes above four divide by 32
                    last_div = (2 << ((divider_code > 3'd4) ? 4 : divider_code)) - 1;
                    if (prescale_count >= prescale_value)
                    begin
                        prescale_count = '0;
                        if (divide_count >= last_div)
                        begin
                            divide_count = '0;
                            fire = 1'b1;
                        end
                        else
                            divide_count = divide_count + 1'b1;
                    end
                    else
                        prescale_count = prescale_count + 1'b1;
                    if (fire && running)
                    begin
                        if (current_count == '0)
                        begin
                            if (reload_enable)
                            begin
                                current_count = count_buffer;
                                w.interrupt_pulse = (count_buffer == '0);
                            end
                            else
                                running = 1'b0;
                        end
                        else
                        begin
                            current_count = current_count - 1'b1;
                            if (current_count == '0)
                            begin
                                if (!reload_enable)
                                    running = 1'b0;
                                w.interrupt_pulse = 1'b1;
                            end
                        end
                    end
                end
                OP_WRITE_BUF:
                    count_buffer = wd;
                OP_WRITE_CTRL:
                begin
                    if (wd[CTRL_UPDATE_BIT])
                        current_count = count_buffer;
                    running = wd[CTRL_START_BIT];
                    reload_enable = wd[CTRL_RELOAD_BIT];
                end
                default:
                    w.read_data = current_count;
            endcase
            w.count_is_zero = (current_count == '0);
            expected_words.push_back(w);
        endfunction

        function void check_word(data_t rd, logic zero, logic pulse);
            timer_word_t w;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: read_data %h count_is_zero %b interrupt_pulse %b",
                             rd, zero, pulse);
                return;
            end
            w = expected_words.pop_front();
            if (rd !== w.read_data || zero !== w.count_is_zero || pulse !== w.interrupt_pulse)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: read_data %h/%h count_is_zero %b/%b %s %b/%b",
                             $realtime, w.read_data, rd, w.count_is_zero, zero,
                             "interrupt_pulse", w.interrupt_pulse, pulse);
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   hold_left     = 0;

    timer_scoreboard sb = new();

    pdct_cmd_if cmd();
    pdct_rsp_if rsp();
    pdct_cfg_if cfg();

    prescaled_down_counter_timer_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2400000;
        $display("Simulation FAILED");
        $finish;
    end

    // response side: random stalls plus long hold-offs counted here
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                sb.check_word(rsp.read_data, rsp.count_is_zero, rsp.interrupt_pulse);
            if (cfg.valid && cfg.ready)
                sb.set_register(cfg.index, cfg.data);
            if (cmd.valid && cmd.ready)
                sb.note_command(cmd.opcode, cmd.write_data);
        end
    end

    // all driving tasks start and end at a falling edge
    task automatic send_command(input opcode_t op, input data_t wd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.opcode     <= op;
        cmd.write_data <= wd;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input cfg_data_t val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic configure(input cfg_data_t presc, input cfg_data_t divsel);
        write_register(REG_PRESCALE, presc);
        write_register(REG_DIVIDER, divsel);
        // writes to unused indexes must be ignored
        write_register(cfg_index_t'($urandom_range(LAST_INDEX, FIRST_UNUSED_INDEX)),
                       cfg_data_t'($urandom));
        cfg.valid <= 1'b0;
    endtask

    task automatic run_random(input int items);
        int    sent;
        int    run_len;
        data_t ctrl;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(9) < 7)
            begin
                // load, start, then a run of ticks with the odd read
                send_command(OP_WRITE_BUF, ($urandom_range(7) == 0) ?
                             data_t'($urandom) : data_t'($urandom_range(12)));
                ctrl = data_t'($urandom);
                ctrl[CTRL_START_BIT]  = 1'b1;
                ctrl[CTRL_UPDATE_BIT] = ($urandom_range(3) != 0);
                ctrl[CTRL_RELOAD_BIT] = 1'($urandom_range(1));
                send_command(OP_WRITE_CTRL, ctrl);
                run_len = $urandom_range(40, 8);
                repeat (run_len)
                    send_command(($urandom_range(7) == 0) ? OP_READ_COUNT : OP_TICK, '0);
                sent += run_len + 2;
            end
            else
            begin
                run_len = $urandom_range(6, 1);
                repeat (run_len)
                    send_command(opcode_t'($urandom_range(OP_READ_COUNT, OP_TICK)),
                                 data_t'($urandom));
                sent += run_len;
            end
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input cfg_data_t presc,
                             input cfg_data_t divsel, input int items, input int hold);
        drain();
        send_idle_pct = idle;
        stall_pct     = stall;
        configure(presc, divsel);
        if (hold > 0)
        begin
            run_random(items / 2);
            hold_left = hold;
            run_random(items - items / 2);
        end
        else
            run_random(items);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cmd.valid      = 1'b0;
        cmd.opcode     = OP_TICK;
        cmd.write_data = '0;
        cfg.valid      = 1'b0;
        cfg.index      = REG_PRESCALE;
        cfg.data       = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        configure(8'd0, 8'd0);
        send_command(OP_READ_COUNT, 16'hffff);
        send_command(OP_TICK, 16'hffff);
        send_command(OP_WRITE_BUF, 16'hffff);
        // manual update without start
        send_command(OP_WRITE_CTRL, 16'h0002);
        send_command(OP_READ_COUNT, '0);
        send_command(OP_WRITE_CTRL, 16'h0001);
        repeat (2) send_command(OP_TICK, '0);
        send_command(OP_READ_COUNT, '0);
        // auto-reload through zero
        send_command(OP_WRITE_BUF, 16'h0001);
        send_command(OP_WRITE_CTRL, 16'h000b);
        repeat (4) send_command(OP_TICK, '0);
        // reload of a zero buffer pulses on every count
        send_command(OP_WRITE_BUF, 16'h0000);
        send_command(OP_WRITE_CTRL, 16'h000b);
        repeat (2) send_command(OP_TICK, '0);
        // one shot reaching zero
        send_command(OP_WRITE_BUF, 16'h0002);
        send_command(OP_WRITE_CTRL, 16'h0003);
        repeat (4) send_command(OP_TICK, '0);
        // one shot counting at zero, ignored control bits set
        send_command(OP_WRITE_CTRL, 16'hfff5);
        repeat (2) send_command(OP_TICK, '0);
        send_command(OP_WRITE_CTRL, 16'hffff);
        send_command(OP_READ_COUNT, '0);

        run_phase(0, 0, 8'd0, 8'd1, 100, 150);
        run_phase(81, 0, 8'd1, 8'd0, 100, 0);
        run_phase(0, 81, 8'd0, 8'hf7, 100, 0);
        run_phase(31, 31, 8'd3, 8'd2, 100, 0);
        run_phase(31, 31, 8'd0, 8'd5, 60, 0);
        run_phase(0, 0, 8'd255, 8'd0, 60, 0);

        drain();
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
